// ----- sv/swsel_pkg.sv -----
// Types, constants and byte classification shared by the smallest word selector.
package swsel_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] word_byte;
        logic       no_word;
        logic       word_truncated;
        logic       last_byte;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_SEP  = 2'd1,
        KIND_EOT  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_q_item;

    typedef enum logic [1:0] {
        ORD_EQUAL   = 2'd0,
        ORD_LESS    = 2'd1,
        ORD_GREATER = 2'd2
    } t_order;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_EMIT = 2'b10
    } t_back_state;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c - CH_UPPER_A + CH_LOWER_A;
        end
        return r;
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        logic r;
        unique case (c) inside
            8'h00, 8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h21,
            8'h3F, 8'h2D, 8'h27, 8'h22, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
            8'h2F, 8'h5C, 8'h3C, 8'h3E, 8'h7C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/swsel_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module swsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/swsel_front.sv -----
// Front end: case folding and separator classification of incoming items.
module swsel_front (
    input  logic               i_in_valid,
    input  swsel_pkg::t_in_item i_in_item,
    input  logic               i_full,
    output logic               o_in_stall,
    output logic               o_push,
    output swsel_pkg::t_q_item o_q_item
);

    logic [7:0] folded;

    assign folded     = swsel_pkg::fold_case(i_in_item.text_byte);
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_q_item.data = folded;
        if (i_in_item.end_of_text) begin
            o_q_item.kind = swsel_pkg::KIND_EOT;
        end else if (swsel_pkg::is_separator(folded)) begin
            o_q_item.kind = swsel_pkg::KIND_SEP;
        end else begin
            o_q_item.kind = swsel_pkg::KIND_TEXT;
        end
    end

endmodule

// ----- sv/swsel_queue.sv -----
// Short item queue between the front end and the word engine.
module swsel_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  swsel_pkg::t_q_item i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output swsel_pkg::t_q_item o_data,
    output logic               o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    swsel_pkg::t_q_item r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);

endmodule

// ----- sv/swsel_back.sv -----
// Word engine: running comparison, best word bank swap and answer emission.
module swsel_back #(
    parameter int WORD_LEN = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  swsel_pkg::t_q_item  i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output swsel_pkg::t_out_item o_out_item
);

    localparam int IW    = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
    localparam int LW    = $clog2(WORD_LEN + 1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [LW-1:0] WL = LW'(WORD_LEN);

    swsel_pkg::t_back_state r_state, n_state;
    swsel_pkg::t_order      r_order, n_order;
    logic [LW-1:0]          r_cur_len, n_cur_len;
    logic                   r_cur_ovf, n_cur_ovf;
    logic                   r_cur_sel, n_cur_sel;
    logic [LW-1:0]          r_best_len, n_best_len;
    logic                   r_best_ovf, n_best_ovf;
    logic                   r_have_best, n_have_best;
    logic [LW-1:0]          r_emit_idx, n_emit_idx;
    logic                   r_out_valid, n_out_valid;
    swsel_pkg::t_out_item   r_out, n_out;

    logic          take;
    logic          out_free;
    logic          load;
    logic          last;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    swsel_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_q_item.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign take = (r_cur_len != '0) &&
                  (!r_have_best || r_order == swsel_pkg::ORD_LESS ||
                   (r_order == swsel_pkg::ORD_EQUAL && r_cur_len < r_best_len));
    assign out_free = !r_out_valid || !i_out_stall;
    assign last     = (({1'b0, r_emit_idx} + (LW + 1)'(1)) == {1'b0, r_best_len});
    assign o_q_pop  = (r_state == swsel_pkg::ST_RUN) && i_q_valid;
    assign waddr    = {r_cur_sel, r_cur_len[IW-1:0]};

    always_comb begin
        n_state     = r_state;
        n_order     = r_order;
        n_cur_len   = r_cur_len;
        n_cur_ovf   = r_cur_ovf;
        n_cur_sel   = r_cur_sel;
        n_best_len  = r_best_len;
        n_best_ovf  = r_best_ovf;
        n_have_best = r_have_best;
        n_emit_idx  = r_emit_idx;
        n_out       = r_out;
        we          = 1'b0;
        load        = 1'b0;
        unique case (r_state)
            swsel_pkg::ST_RUN: begin
                if (o_q_pop) begin
                    unique case (i_q_item.kind) inside
                        swsel_pkg::KIND_TEXT: begin
                            if (r_cur_len >= WL) begin
                                n_cur_ovf = 1'b1;
                            end else begin
                                if (r_have_best && r_order == swsel_pkg::ORD_EQUAL) begin
                                    if (r_cur_len >= r_best_len) begin
                                        n_order = swsel_pkg::ORD_GREATER;
                                    end else if (i_q_item.data < rdata) begin
                                        n_order = swsel_pkg::ORD_LESS;
                                    end else if (i_q_item.data > rdata) begin
                                        n_order = swsel_pkg::ORD_GREATER;
                                    end
                                end
                                we        = 1'b1;
                                n_cur_len = r_cur_len + LW'(1);
                            end
                        end
                        swsel_pkg::KIND_SEP, swsel_pkg::KIND_EOT: begin
                            if (take) begin
                                n_cur_sel   = ~r_cur_sel;
                                n_best_len  = r_cur_len;
                                n_best_ovf  = r_cur_ovf;
                                n_have_best = 1'b1;
                            end
                            n_cur_len = '0;
                            n_cur_ovf = 1'b0;
                            n_order   = swsel_pkg::ORD_EQUAL;
                            if (i_q_item.kind == swsel_pkg::KIND_EOT) begin
                                n_state    = swsel_pkg::ST_EMIT;
                                n_emit_idx = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            swsel_pkg::ST_EMIT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (!r_have_best) begin
                        n_out.word_byte      = '0;
                        n_out.no_word        = 1'b1;
                        n_out.word_truncated = 1'b0;
                        n_out.last_byte      = 1'b1;
                    end else begin
                        n_out.word_byte      = rdata;
                        n_out.no_word        = 1'b0;
                        n_out.word_truncated = r_best_ovf;
                        n_out.last_byte      = last;
                    end
                    if (!r_have_best || last) begin
                        n_state     = swsel_pkg::ST_RUN;
                        n_have_best = 1'b0;
                        n_best_len  = '0;
                        n_best_ovf  = 1'b0;
                        n_emit_idx  = '0;
                    end else begin
                        n_emit_idx = r_emit_idx + LW'(1);
                    end
                end
            end
            default: begin
                n_state = swsel_pkg::ST_RUN;
            end
        endcase
        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    // prefetch the best word byte for the next cycle's compare or emit
    assign raddr = {~n_cur_sel, (n_state == swsel_pkg::ST_EMIT) ?
                    n_emit_idx[IW-1:0] : n_cur_len[IW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swsel_pkg::ST_RUN;
            r_order     <= swsel_pkg::ORD_EQUAL;
            r_cur_len   <= '0;
            r_cur_ovf   <= 1'b0;
            r_cur_sel   <= 1'b0;
            r_best_len  <= '0;
            r_best_ovf  <= 1'b0;
            r_have_best <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_order     <= n_order;
            r_cur_len   <= n_cur_len;
            r_cur_ovf   <= n_cur_ovf;
            r_cur_sel   <= n_cur_sel;
            r_best_len  <= n_best_len;
            r_best_ovf  <= n_best_ovf;
            r_have_best <= n_have_best;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_cur_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_len <= WL)
        else $error("current word length beyond limit");

    a_best_len_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_best |-> (r_best_len != '0 && r_best_len <= WL))
        else $error("best word length invalid");

    a_no_best_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_best |-> (r_best_len == '0))
        else $error("best length set without a best word");

    a_emit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swsel_pkg::ST_EMIT && r_have_best) |-> (r_emit_idx < r_best_len))
        else $error("emit index past best word");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_out.last_byte) |=> (r_state == swsel_pkg::ST_RUN && !r_have_best))
        else $error("engine not cleared after final result");
`endif

endmodule

// ----- sv/smallest_word_selector_top.sv -----
// Top level of the smallest word selector: front end, item queue and word engine.
// Text items are accepted one per cycle while the queue has room, and the engine
// takes one per cycle while it runs: the front end folds case and classifies
// separators, and the engine compares each byte against the stored best word as it
// arrives, so a word is settled the moment a separator comes in. The end-of-text
// item makes the engine close the last word and emit the smallest word (or a
// no-word item if there is none) one byte per cycle while the output is not
// stalled, paced by the output register; while it emits, new items still enter
// the queue of QUEUE_DEPTH entries and input stall rises only when it is full.
// Words are held in one RAM of two banks that swap roles when a new best word
// is chosen; there is no clearing pass after reset.
module smallest_word_selector_top #(
    parameter int WORD_LEN    = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swsel_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swsel_pkg::t_out_item o_out_item
);

    logic               push;
    logic               full;
    logic               q_valid;
    logic               q_pop;
    swsel_pkg::t_q_item front_item;
    swsel_pkg::t_q_item q_item;

    swsel_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_q_item   (front_item)
    );

    swsel_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item),
        .o_full  (full)
    );

    swsel_back #(
        .WORD_LEN(WORD_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
